// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define LPG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpg assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define LPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpg assertion failed");

`endif

// File: hdl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Types and constants shared by the line point generator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package lpg_pkg;

  localparam int LPG_CW      = 8;   // coordinate width
  localparam int LPG_PTS_MAX = 4;   // point slots per result transaction
  localparam int LPG_PTS_DEF = 4;   // default points per result
  localparam int LPG_MAX_RES = 64;  // result cap per line
  localparam int LPG_RES_W   = 6;   // result counter width
  localparam int LPG_CNT_W   = 3;   // point_count width

  typedef logic [LPG_CW-1:0]    coord_t;
  typedef logic [LPG_CNT_W-1:0] pcount_t;

  // one generated point handed to the packer
  typedef struct packed {
    logic   vld;
    logic   last;
    coord_t x;
    coord_t y;
  } lpg_pt_t;

endpackage
`default_nettype wire

// File: hdl/lpg_step.sv
// ----------------------------------------------------------------------------
// lpg_step
// Shared add/compare/subtract unit: advances minor-axis quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module lpg_step (
  input  lpg_pkg::coord_t rem_i,   // remainder, always < len
  input  lpg_pkg::coord_t q_i,
  input  lpg_pkg::coord_t dabs_i,  // |dminor|, <= len
  input  lpg_pkg::coord_t len_i,
  output lpg_pkg::coord_t rem_o,
  output lpg_pkg::coord_t q_o
);
  import lpg_pkg::*;

  logic [LPG_CW:0] sum;
  logic [LPG_CW:0] dif;
  logic            ge;

  assign sum   = {1'b0, rem_i} + {1'b0, dabs_i};
  assign dif   = sum - {1'b0, len_i};
  assign ge    = (sum >= {1'b0, len_i});
  assign rem_o = ge ? dif[LPG_CW-1:0] : sum[LPG_CW-1:0];
  assign q_o   = q_i + {{(LPG_CW-1){1'b0}}, ge};

endmodule
`default_nettype wire

// File: hdl/lpg_pack.sv
// ----------------------------------------------------------------------------
// lpg_pack
// Gathers points into groups and drives the registered result transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module lpg_pack #(
  parameter int POINTS_PER_RESULT = lpg_pkg::LPG_PTS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      clr_i,   // new line
  input  lpg_pkg::lpg_pt_t                          pt_i,
  output logic                                      done_o,  // line finished
  output logic                                      valid_o,
  output logic [lpg_pkg::LPG_PTS_MAX-1:0][lpg_pkg::LPG_CW-1:0] px_o,
  output logic [lpg_pkg::LPG_PTS_MAX-1:0][lpg_pkg::LPG_CW-1:0] py_o,
  output lpg_pkg::pcount_t                          count_o,
  output logic                                      last_o
);
  import lpg_pkg::*;

  localparam logic [1:0] GLAST = 2'(POINTS_PER_RESULT - 1);

  logic [1:0]           k_r, k_nxt;
  logic [LPG_RES_W-1:0] res_r, res_nxt;
  coord_t               sx_r [LPG_PTS_MAX];
  coord_t               sy_r [LPG_PTS_MAX];
  logic                 close, cap, fin;

  assign close  = pt_i.vld && (pt_i.last || (k_r == GLAST));
  assign cap    = (res_r == LPG_RES_W'(LPG_MAX_RES - 1));
  assign fin    = pt_i.last || cap;
  assign done_o = close && fin;

  always_comb begin
    k_nxt   = k_r;
    res_nxt = res_r;
    if (clr_i) begin
      k_nxt   = '0;
      res_nxt = '0;
    end else if (close) begin
      k_nxt   = '0;
      res_nxt = res_r + 1'b1;
    end else if (pt_i.vld) begin
      k_nxt   = k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      res_r   <= '0;
      valid_o <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      res_r   <= res_nxt;
      valid_o <= close;
    end
  end

  // slot storage, payload only
  always_ff @(posedge clk) begin
    if (pt_i.vld) begin
      sx_r[k_r] <= pt_i.x;
      sy_r[k_r] <= pt_i.y;
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      for (int j = 0; j < LPG_PTS_MAX; j++) begin
        if (2'(j) < k_r) begin
          px_o[j] <= sx_r[j];
          py_o[j] <= sy_r[j];
        end else if (2'(j) == k_r) begin
          px_o[j] <= pt_i.x;
          py_o[j] <= pt_i.y;
        end else begin
          px_o[j] <= '0;
          py_o[j] <= '0;
        end
      end
      count_o <= {1'b0, k_r} + 3'd1;
      last_o  <= fin;
    end
  end

endmodule
`default_nettype wire

// File: hdl/line_point_generator.sv
// Sequence: an accepted start enters a setup state, then the walk runs one shared step-unit
//   iteration per point; a result closes every G points (G = POINTS_PER_RESULT), the last may be short.
// A line of N = |dmajor|+1 points keeps busy high through setup and the walk;
//   the next command is taken only once busy has dropped again.
// Results are one-cycle strobes on out_valid; the receiver cannot stall them.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
// line_point_generator
// DDA line rasterizer: emits pixel coordinates of a line in groups of points.
// ----------------------------------------------------------------------------
`default_nettype none
module line_point_generator #(
  parameter int POINTS_PER_RESULT = lpg_pkg::LPG_PTS_DEF  // 1 .. 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // command transaction
  input  logic              start,
  output logic              busy,
  input  lpg_pkg::coord_t   in_x_start,
  input  lpg_pkg::coord_t   in_y_start,
  input  lpg_pkg::coord_t   in_x_end,
  input  lpg_pkg::coord_t   in_y_end,
  // result transaction
  output logic              out_valid,
  output lpg_pkg::coord_t   out_px_a,
  output lpg_pkg::coord_t   out_py_a,
  output lpg_pkg::coord_t   out_px_b,
  output lpg_pkg::coord_t   out_py_b,
  output lpg_pkg::coord_t   out_px_c,
  output lpg_pkg::coord_t   out_py_c,
  output lpg_pkg::coord_t   out_px_d,
  output lpg_pkg::coord_t   out_py_d,
  output lpg_pkg::pcount_t  out_point_count,
  output logic              out_last_group
);
  import lpg_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state_r, state_nxt;

  // captured endpoints
  coord_t xs_r, ys_r, xe_r, ye_r;

  // per-line setup values
  logic   xmaj_r;   // x is the major axis
  logic   down_r;   // major coordinate decrements
  logic   neg_r;    // minor delta is negative
  coord_t len_r;    // |dmajor|
  coord_t dabs_r;   // |dminor|
  coord_t nst_r;    // minor start

  // iteration state
  coord_t maj_r, i_r, rem_r, q_r;
  coord_t rem_step, q_step;

  // setup arithmetic, combinational from captured endpoints, registered in the setup state
  logic [LPG_CW:0] dx, dy;
  coord_t          adx, ady;
  logic            xmaj_s;

  coord_t  mnr;
  lpg_pt_t pt;
  logic    done;
  logic    clr;
  logic [LPG_PTS_MAX-1:0][LPG_CW-1:0] px, py;

  assign dx     = {1'b0, xe_r} - {1'b0, xs_r};
  assign dy     = {1'b0, ye_r} - {1'b0, ys_r};
  assign adx    = dx[LPG_CW] ? LPG_CW'(-dx) : dx[LPG_CW-1:0];
  assign ady    = dy[LPG_CW] ? LPG_CW'(-dy) : dy[LPG_CW-1:0];
  assign xmaj_s = (adx > ady);  // ties go to y

  assign busy = (state_r != ST_IDLE);
  assign clr  = (state_r == ST_SETUP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_RUN;
      ST_RUN:   if (done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture on an accepted command transaction
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      xs_r <= in_x_start;
      ys_r <= in_y_start;
      xe_r <= in_x_end;
      ye_r <= in_y_end;
    end
  end

  // setup registers, then the per-point walk
  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP) begin
      xmaj_r <= xmaj_s;
      down_r <= xmaj_s ? dx[LPG_CW] : dy[LPG_CW];
      neg_r  <= xmaj_s ? dy[LPG_CW] : dx[LPG_CW];
      len_r  <= xmaj_s ? adx : ady;
      dabs_r <= xmaj_s ? ady : adx;
      nst_r  <= xmaj_s ? ys_r : xs_r;
      maj_r  <= xmaj_s ? xs_r : ys_r;
      i_r    <= '0;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (state_r == ST_RUN) begin
      maj_r <= down_r ? maj_r - 1'b1 : maj_r + 1'b1;
      i_r   <= i_r + 1'b1;
      rem_r <= rem_step;
      q_r   <= q_step;
    end
  end

  // minor offset = sign * floor(|dminor| * i / len), i.e. truncation toward zero
  lpg_step u_step (
    .rem_i  (rem_r),
    .q_i    (q_r),
    .dabs_i (dabs_r),
    .len_i  (len_r),
    .rem_o  (rem_step),
    .q_o    (q_step)
  );

  assign mnr     = neg_r ? nst_r - q_r : nst_r + q_r;
  assign pt.vld  = (state_r == ST_RUN);
  assign pt.last = (i_r == len_r);
  assign pt.x    = xmaj_r ? maj_r : mnr;
  assign pt.y    = xmaj_r ? mnr : maj_r;

  lpg_pack #(
    .POINTS_PER_RESULT (POINTS_PER_RESULT)
  ) u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_i   (clr),
    .pt_i    (pt),
    .done_o  (done),
    .valid_o (out_valid),
    .px_o    (px),
    .py_o    (py),
    .count_o (out_point_count),
    .last_o  (out_last_group)
  );

  assign out_px_a = px[0];
  assign out_py_a = py[0];
  assign out_px_b = px[1];
  assign out_py_b = py[1];
  assign out_px_c = px[2];
  assign out_py_c = py[2];
  assign out_px_d = px[3];
  assign out_py_d = py[3];

endmodule
`default_nettype wire

// File: hdl/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks for line_point_generator, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lpg_checker #(
  parameter int POINTS_PER_RESULT = lpg_pkg::LPG_PTS_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input lpg_pkg::coord_t  out_px_b,
  input lpg_pkg::coord_t  out_py_b,
  input lpg_pkg::pcount_t out_point_count,
  input logic             out_last_group
);
  import lpg_pkg::*;

  localparam pcount_t GFULL = LPG_CNT_W'(POINTS_PER_RESULT);

  logic short_grp;
  logic single_pt;
  logic b_zero;

  assign short_grp = out_valid && (out_point_count != GFULL);
  assign single_pt = out_valid && (out_point_count == 3'd1);
  assign b_zero    = (out_px_b == '0) && (out_py_b == '0);

  // a short group only closes a line
  `LPG_ASSERT_SAME(a_short_is_last, short_grp, out_last_group)
  // unused slot b reads as zero
  `LPG_ASSERT_SAME(a_slot_b_zero, single_pt, b_zero)
  // the final transaction of a line coincides with idle
  `LPG_ASSERT_SAME(a_last_idle, out_valid && out_last_group, !busy)
  // an accepted command is followed by busy
  `LPG_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)

endmodule

bind line_point_generator lpg_checker #(
  .POINTS_PER_RESULT (POINTS_PER_RESULT)
) u_lpg_checker (.*);
`default_nettype wire
